@@ rtl/min_cost_assignment_solver_core_assert.svh @@
// Assertion macros for the assignment solver.
`ifndef MIN_COST_ASSIGNMENT_SOLVER_CORE_ASSERT_SVH
`define MIN_COST_ASSIGNMENT_SOLVER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MCAS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mcas assertion failed");
`define MCAS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mcas assertion failed");
`else
`define MCAS_ASSERT_IMP(lbl, ante, cons)
`define MCAS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/mcas_pkg.sv @@
// Shared constants, types and state codes for the assignment solver.
package mcas_pkg;
  localparam int MAX_ROWS    = 16;
  localparam int MAX_COLUMNS = 16;
  localparam int COST_BITS   = 16;
  localparam int POT_BITS    = 32;
  localparam int CFG_W       = 5;
  localparam int RIDX_W      = $clog2(MAX_ROWS + 1);
  localparam int CIDX_W      = $clog2(MAX_COLUMNS + 1);
  localparam int GUARD_W     = $clog2(MAX_COLUMNS + 2);
  localparam int ROW_W       = 4;
  localparam int COL_W       = 4;
  localparam int POS_LIMIT   = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W      = $clog2(POS_LIMIT);
  localparam int POS_W       = $clog2(POS_LIMIT + 1);

  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  typedef logic signed [POT_BITS-1:0]  pot_t;
  typedef logic signed [COST_BITS-1:0] cost_t;
  typedef logic [RIDX_W-1:0]           ridx_t;
  typedef logic [CIDX_W-1:0]           cidx_t;

  localparam pot_t POT_MAX = {1'b0, {(POT_BITS-1){1'b1}}};

  typedef struct packed {
    cost_t cost;
    pot_t  urow;
    pot_t  vcol;
    pot_t  minv;
    pot_t  delta;
  } slack_req_t;

  typedef struct packed {
    logic less;
    logic better;
    pot_t slack;
  } slack_rsp_t;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_ROW_INIT = 9'b000000010,
    S_STEP     = 9'b000000100,
    S_READ     = 9'b000001000,
    S_CALC     = 9'b000010000,
    S_UPDATE   = 9'b000100000,
    S_AUG      = 9'b001000000,
    S_COLLECT  = 9'b010000000,
    S_EMIT     = 9'b100000000
  } state_t;
endpackage

@@ rtl/mcas_cost_ram.sv @@
// Cost matrix storage: one write port, one registered read port.
module mcas_cost_ram
  import mcas_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  cost_t             wdata,
  input  logic [ADDR_W-1:0] raddr,
  output cost_t             rdata
);
  cost_t mem [0:POS_LIMIT-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/mcas_slack_unit.sv @@
// Shared reduced-cost unit: slack, running minimum and delta compare.
module mcas_slack_unit
  import mcas_pkg::*;
(
  input  slack_req_t req,
  output slack_rsp_t rsp
);
  pot_t cur;
  pot_t pick;

  always_comb begin
    cur        = POT_BITS'(req.cost) - req.urow - req.vcol;
    rsp.less   = (cur < req.minv);
    pick       = rsp.less ? cur : req.minv;
    rsp.slack  = pick;
    rsp.better = (pick < req.delta);
  end
endmodule

@@ rtl/min_cost_assignment_solver_core.sv @@
// Top level of the minimum-cost assignment solver.
// Cost entries are taken one per cycle while busy is low, in row-major order; the entry
// with last_entry set starts a solve and busy stays high until the last result. Each
// augmenting step of a row takes one cost memory read and one pass of the shared slack
// unit per column, then one potential update per column; a row needs one setup state,
// at most n steps and a walk back along the augmenting path, followed after the last
// row by a pass over the columns to collect the matching. Then n results come
// out on consecutive cycles, one per row, each marked by result_valid for a single
// cycle; the receiver cannot stall them. With more rows than columns no solve runs and
// every row reports unassigned.
`include "min_cost_assignment_solver_core_assert.svh"
module min_cost_assignment_solver_core
  import mcas_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cost_t            cost_value,
  input  logic             last_entry,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             result_valid,
  output logic [ROW_W-1:0] row_index,
  output logic [COL_W-1:0] column_index,
  output logic             assigned,
  output logic             last_result
);
  state_t state;
  logic [CFG_W-1:0] row_count;
  logic [CFG_W-1:0] column_count;
  logic [POS_W-1:0] load_pos;
  ridx_t load_row;
  cidx_t load_col;

  pot_t  row_pot [0:MAX_ROWS];
  pot_t  col_pot [0:MAX_COLUMNS];
  pot_t  minv    [0:MAX_COLUMNS];
  ridx_t match   [0:MAX_COLUMNS];
  cidx_t way     [0:MAX_COLUMNS];
  logic [MAX_COLUMNS:0] used;
  logic [COL_W-1:0] col_of [0:MAX_ROWS-1];
  logic [MAX_ROWS-1:0] has;

  ridx_t i;
  ridx_t i0;
  cidx_t j;
  cidx_t j0;
  cidx_t j1;
  logic [GUARD_W-1:0] guard;
  pot_t urow;
  pot_t delta;
  ridx_t r;

  ridx_t n;
  cidx_t m;
  logic [POS_W-1:0] nm;
  logic accept;
  logic load_we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  cost_t rdata;
  slack_req_t sreq;
  slack_rsp_t srsp;
  cidx_t j1_next;
  ridx_t i0_next;
  ridx_t pr;
  cidx_t jb;

  always_comb begin
    if (row_count == '0) begin
      n = RIDX_W'(1);
    end else if (row_count > CFG_W'(MAX_ROWS)) begin
      n = RIDX_W'(MAX_ROWS);
    end else begin
      n = RIDX_W'(row_count);
    end
    if (column_count == '0) begin
      m = CIDX_W'(1);
    end else if (column_count > CFG_W'(MAX_COLUMNS)) begin
      m = CIDX_W'(MAX_COLUMNS);
    end else begin
      m = CIDX_W'(column_count);
    end
    nm      = POS_W'(n) * POS_W'(m);
    accept  = start && !busy;
    load_we = accept && (load_pos < nm);
    waddr   = ADDR_W'(load_row * MAX_COLUMNS + load_col);
    raddr   = ADDR_W'((i0 - 1) * MAX_COLUMNS + (j - 1));
    sreq.cost  = rdata;
    sreq.urow  = urow;
    sreq.vcol  = col_pot[j];
    sreq.minv  = minv[j];
    sreq.delta = delta;
    j1_next = (!used[j] && srsp.better) ? j : j1;
    i0_next = match[j0];
    if (i0_next == '0 || i0_next > n) begin
      i0_next = RIDX_W'(1);
    end
    pr = match[j];
    jb = way[j0];
    if (jb > m) begin
      jb = '0;
    end
  end

  mcas_cost_ram u_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (waddr),
    .wdata (cost_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  mcas_slack_unit u_slack (
    .req (sreq),
    .rsp (srsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      row_count    <= CFG_W'(16);
      column_count <= CFG_W'(16);
      load_pos     <= '0;
      load_row     <= '0;
      load_col     <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ROW_COUNT:    row_count    <= cfg_data;
          REG_COLUMN_COUNT: column_count <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (last_entry) begin
              load_pos <= '0;
              load_row <= '0;
              load_col <= '0;
              has      <= '0;
              r        <= '0;
              i        <= RIDX_W'(1);
              for (int k = 0; k <= MAX_ROWS; k++) begin
                row_pot[k] <= '0;
              end
              for (int k = 0; k <= MAX_COLUMNS; k++) begin
                col_pot[k] <= '0;
                match[k]   <= '0;
                way[k]     <= '0;
              end
              state <= (n <= RIDX_W'(m)) ? S_ROW_INIT : S_EMIT;
            end else begin
              if (load_we) begin
                if (load_col == m - 1) begin
                  load_col <= '0;
                  load_row <= load_row + 1'b1;
                end else begin
                  load_col <= load_col + 1'b1;
                end
              end
              if (load_pos < POS_W'(POS_LIMIT)) begin
                load_pos <= load_pos + 1'b1;
              end
            end
          end
        end
        S_ROW_INIT: begin
          for (int k = 0; k <= MAX_COLUMNS; k++) begin
            minv[k] <= POT_MAX;
          end
          used     <= '0;
          match[0] <= i;
          j0       <= '0;
          state    <= S_STEP;
        end
        S_STEP: begin
          used[j0] <= 1'b1;
          i0       <= i0_next;
          urow     <= row_pot[i0_next];
          delta    <= POT_MAX;
          j1       <= '0;
          j        <= CIDX_W'(1);
          state    <= S_READ;
        end
        S_READ: begin
          state <= S_CALC;
        end
        S_CALC: begin
          if (!used[j]) begin
            if (srsp.less) begin
              minv[j] <= srsp.slack;
              way[j]  <= j0;
            end
            if (srsp.better) begin
              delta <= srsp.slack;
            end
          end
          j1 <= j1_next;
          if (j == m) begin
            if (j1_next == '0) begin
              guard <= '0;
              state <= S_AUG;
            end else begin
              j     <= '0;
              state <= S_UPDATE;
            end
          end else begin
            j     <= j + 1'b1;
            state <= S_READ;
          end
        end
        S_UPDATE: begin
          if (used[j]) begin
            if (pr <= n) begin
              row_pot[pr] <= row_pot[pr] + delta;
            end
            col_pot[j] <= col_pot[j] - delta;
          end else begin
            minv[j] <= minv[j] - delta;
          end
          if (j == m) begin
            j0 <= j1;
            if (match[j1] != '0) begin
              state <= S_STEP;
            end else begin
              guard <= '0;
              state <= S_AUG;
            end
          end else begin
            j <= j + 1'b1;
          end
        end
        S_AUG: begin
          if (j0 != '0 && guard <= GUARD_W'(m)) begin
            match[j0] <= match[jb];
            j0        <= jb;
            guard     <= guard + 1'b1;
          end else if (i == n) begin
            j     <= CIDX_W'(1);
            state <= S_COLLECT;
          end else begin
            i     <= i + 1'b1;
            state <= S_ROW_INIT;
          end
        end
        S_COLLECT: begin
          if (pr != '0 && pr <= n) begin
            col_of[ROW_W'(pr - 1)] <= COL_W'(j - 1);
            has[ROW_W'(pr - 1)]    <= 1'b1;
          end
          if (j == m) begin
            state <= S_EMIT;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_EMIT: begin
          if (r == n - 1) begin
            state <= S_IDLE;
          end else begin
            r <= r + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    busy         = (state != S_IDLE);
    result_valid = (state == S_EMIT);
    row_index    = ROW_W'(r);
    assigned     = has[ROW_W'(r)];
    column_index = has[ROW_W'(r)] ? col_of[ROW_W'(r)] : '0;
    last_result  = (r == n - 1);
  end

  `MCAS_ASSERT_IMP(a_result_busy, result_valid, busy)
  `MCAS_ASSERT_IMP(a_result_row_range, result_valid, r < n)
  `MCAS_ASSERT_NEXT(a_last_frees, result_valid && last_result, !busy)
  `MCAS_ASSERT_NEXT(a_plain_entry_idle, start && !busy && !last_entry, !busy)
endmodule

@@ sim/mcas_checker.sv @@
// Assignment solver checker: tracks requests, predicts row assignments, compares results.
module mcas_checker
  import mcas_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  cost_t            cost_value,
  input  logic             last_entry,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             result_valid,
  input  logic [ROW_W-1:0] row_index,
  input  logic [COL_W-1:0] column_index,
  input  logic             assigned,
  input  logic             last_result,
  output int               fail_count,
  output int               pending
);
  typedef struct {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             asg;
    logic             last;
  } row_assign_t;

  localparam longint SLACK_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

  row_assign_t      assign_q[$];
  cost_t            cost_mem [POS_LIMIT];
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;
  int               load_pos;

  function automatic int in_use(logic [CFG_W-1:0] v, int top);
    if (v == 0) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  task automatic solve_assignment(int n, int m);
    longint      u [MAX_ROWS+1];
    longint      v [MAX_COLUMNS+1];
    longint      minv [MAX_COLUMNS+1];
    int          match [MAX_COLUMNS+1];
    int          way [MAX_COLUMNS+1];
    bit          used [MAX_COLUMNS+1];
    int          col_of [MAX_ROWS];
    bit          has [MAX_ROWS];
    int          j0, j1, i0, guard, p;
    longint      delta, cur;
    row_assign_t ra;
    foreach (u[k]) u[k] = 0;
    foreach (v[k]) v[k] = 0;
    foreach (match[k]) match[k] = 0;
    foreach (way[k]) way[k] = 0;
    foreach (has[k]) begin
      has[k] = 0;
      col_of[k] = 0;
    end
    if (n <= m) begin
      for (int i = 1; i <= n; i++) begin
        j0 = 0;
        for (int j = 0; j <= m; j++) begin
          minv[j] = SLACK_TOP;
          used[j] = 0;
        end
        match[0] = i;
        do begin
          used[j0] = 1;
          i0 = match[j0];
          j1 = 0;
          delta = SLACK_TOP;
          if (i0 == 0 || i0 > n) i0 = 1;
          for (int j = 1; j <= m; j++) begin
            if (!used[j]) begin
              cur = longint'(cost_mem[(i0-1)*MAX_COLUMNS + j-1]) - u[i0] - v[j];
              if (cur < minv[j]) begin
                minv[j] = cur;
                way[j] = j0;
              end
              if (minv[j] < delta) begin
                delta = minv[j];
                j1 = j;
              end
            end
          end
          if (j1 == 0) break;
          for (int j = 0; j <= m; j++) begin
            if (used[j]) begin
              if (match[j] <= n) u[match[j]] += delta;
              v[j] -= delta;
            end else begin
              minv[j] -= delta;
            end
          end
          j0 = j1;
        end while (match[j0] != 0);
        guard = 0;
        while (j0 != 0 && guard <= m) begin
          j1 = way[j0];
          if (j1 > m) j1 = 0;
          match[j0] = match[j1];
          j0 = j1;
          guard++;
        end
      end
      for (int j = 1; j <= m; j++) begin
        p = match[j];
        if (p != 0 && p <= n) begin
          col_of[p-1] = j - 1;
          has[p-1] = 1;
        end
      end
    end
    for (int r = 0; r < n; r++) begin
      ra.row = ROW_W'(r);
      ra.col = has[r] ? COL_W'(col_of[r]) : COL_W'(0);
      ra.asg = has[r];
      ra.last = (r == n - 1);
      assign_q.push_back(ra);
    end
  endtask

  always @(posedge clk) begin
    row_assign_t exp_r;
    int          n, m;
    if (rst) begin
      rows_reg = CFG_W'(MAX_ROWS);
      cols_reg = CFG_W'(MAX_COLUMNS);
      load_pos = 0;
      assign_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_ROW_COUNT) rows_reg = cfg_data;
        if (cfg_index == REG_COLUMN_COUNT) cols_reg = cfg_data;
      end
      if (result_valid) begin
        if (assign_q.size() == 0) begin
          $display("%0t: unexpected result row %0d col %0d assigned %0b last %0b",
                   $time, row_index, column_index, assigned, last_result);
          fail_count++;
        end else begin
          exp_r = assign_q.pop_front();
          if (row_index !== exp_r.row || column_index !== exp_r.col ||
              assigned !== exp_r.asg || last_result !== exp_r.last) begin
            $display("%0t: mismatch exp row %0d col %0d asg %0b last %0b, got %0d %0d %0b %0b",
                     $time, exp_r.row, exp_r.col, exp_r.asg, exp_r.last,
                     row_index, column_index, assigned, last_result);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        n = in_use(rows_reg, MAX_ROWS);
        m = in_use(cols_reg, MAX_COLUMNS);
        if (load_pos < n * m) cost_mem[(load_pos / m) * MAX_COLUMNS + load_pos % m] = cost_value;
        if (load_pos < POS_LIMIT) load_pos++;
        if (last_entry) begin
          load_pos = 0;
          solve_assignment(n, m);
        end
      end
    end
    pending = assign_q.size();
  end
endmodule

@@ sim/tb_top.sv @@
// Testbench top for the assignment solver: clock, reset, cost requests and verdict.
module tb_top;
  import mcas_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  cost_t            cost_value = '0;
  logic             last_entry = 1'b0;
  logic             cfg_write = 1'b0;
  logic             cfg_index = REG_ROW_COUNT;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             result_valid;
  logic [ROW_W-1:0] row_index;
  logic [COL_W-1:0] column_index;
  logic             assigned;
  logic             last_result;
  int               fail_count;
  int               pending;
  int               cycles = 0;
  int               rand_items = 0;

  always #5 clk = ~clk;

  min_cost_assignment_solver_core dut (.*);
  mcas_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_cost(cost_t c, logic lst);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cost_value <= c;
    last_entry <= lst;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic cost_t pick_cost(int style);
    case (style)
      0: return cost_t'($urandom);
      1: return cost_t'($urandom_range(0, 3));
      default: return $urandom_range(0, 1) ? cost_t'(16'h8000) : cost_t'(16'h7FFF);
    endcase
  endfunction

  task automatic load_matrix(int count, int style);
    for (int k = 0; k < count; k++) send_cost(pick_cost(style), k == count - 1);
  endtask

  initial begin
    int n, m, count, style, mode;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // fill the whole store once, extremes first
    send_cost(16'sh8000, 1'b0);
    send_cost(16'sh7FFF, 1'b0);
    send_cost(16'sh0000, 1'b0);
    send_cost(16'shFFFF, 1'b0);
    load_matrix(POS_LIMIT - 4, 0);
    wait_idle();
    write_reg(REG_ROW_COUNT, 5'd0);
    write_reg(REG_COLUMN_COUNT, 5'd31);
    load_matrix(16, 1);
    wait_idle();
    write_reg(REG_ROW_COUNT, 5'd17);
    write_reg(REG_COLUMN_COUNT, 5'd0);
    load_matrix(1, 0);
    wait_idle();
    write_reg(REG_ROW_COUNT, 5'd3);
    write_reg(REG_COLUMN_COUNT, 5'd3);
    load_matrix(12, 1);
    wait_idle();
    load_matrix(4, 2);
    wait_idle();
    while (rand_items < 60) begin
      if ($urandom_range(0, 4) != 0) begin
        n = $urandom_range(1, 5);
        m = $urandom_range(1, 5);
      end else begin
        n = $urandom_range(1, 16);
        m = $urandom_range(1, 16);
      end
      write_reg(REG_ROW_COUNT, CFG_W'(n));
      write_reg(REG_COLUMN_COUNT, CFG_W'(m));
      mode = $urandom_range(0, 19);
      if (mode < 14) count = n * m;
      else if (mode < 17) count = n * m + $urandom_range(1, 4);
      else count = $urandom_range(1, n * m);
      style = $urandom_range(0, 5);
      style = (style < 3) ? 0 : (style < 5) ? 1 : 2;
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        start <= 1'b0;
      end
      load_matrix(count, style);
      rand_items += count;
      wait_idle();
    end
    wait_idle();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
